### src/mts_pkg.sv
// mts_pkg: shared types, sizes and codes for the min-tracking stack
// no dependencies; used by mts_if.sv, mts_store.sv and min_tracking_stack_core.sv
package mts_pkg;

    // store geometry
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // payload types
    typedef logic signed [31:0] t_word;
    typedef logic [1:0]         t_action;
    typedef logic [1:0]         t_status;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CNT_W-1:0]   t_count;

    // action codes
    localparam t_action ACT_PUSH  = 2'd0;
    localparam t_action ACT_POP   = 2'd1;
    localparam t_action ACT_QUERY = 2'd2;

    // status codes
    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    // word constants
    localparam t_word MIN_RESET  = 32'sh7FFF_FFFF;
    localparam t_word EMPTY_WORD = -32'sd1;
    localparam t_word ZERO_WORD  = 32'sd0;

    // single-port memory request
    typedef struct packed {
        logic  en;
        logic  we;
        t_addr addr;
        t_word wdata;
    } t_mem_req;

endpackage

### src/mts_if.sv
// mts_if: valid/ready channel interfaces for the min-tracking stack
// depends on mts_pkg for the payload types
interface mts_in_if;
    logic               valid;
    logic               ready;
    mts_pkg::t_action   action;
    mts_pkg::t_word     push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface mts_out_if;
    logic               valid;
    logic               ready;
    mts_pkg::t_word     result_value;
    mts_pkg::t_status   status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

### src/min_tracking_stack_core.sv
// min_tracking_stack_core: LIFO of signed 32-bit words that tracks its minimum
// depends on mts_pkg, mts_if (mts_in_if, mts_out_if) and mts_store
//
// Usage:
//   i_in carries one command per transfer: action (push, pop, query minimum)
//   and push_value. o_out returns exactly one result per command:
//   result_value and status (ok, empty, full).
//   A push of a value no greater than the minimum stores the old minimum
//   below it; popping the minimum brings the saved one back.
//   Steps per command, set by the single-port store (one access a cycle):
//     query, refused push, pop of an empty stack: no store access
//     push: writes the value, or first the old minimum and then the value
//     pop: reads the top word, then the saved one when the popped word is the minimum
//   The result enters the output register at the edge that ends the command's
//   last cycle if that register is free, so o_out.valid rises in the following cycle.
//   i_in.ready is high whenever no command is in progress; a stalled result
//   sits in the output register and one more in a holding register, and
//   the block waits only when both are full.
//   Reset (i_rst_n low, synchronous) empties the stack and sets the minimum
//   to the largest positive value; memory contents are not cleared.
module min_tracking_stack_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mts_in_if.sink     i_in,
    mts_out_if.source  o_out
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUSH2 = 3'd1;
    localparam logic [2:0] S_POP1  = 3'd2;
    localparam logic [2:0] S_POP2  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]        r_state, n_state;
    mts_pkg::t_count   r_fill, n_fill;
    mts_pkg::t_word    r_min, n_min;
    mts_pkg::t_word    r_val, n_val;
    logic              r_out_valid, n_out_valid;
    mts_pkg::t_word    r_out_value, n_out_value;
    mts_pkg::t_status  r_out_status, n_out_status;
    mts_pkg::t_word    r_pend_value, n_pend_value;
    mts_pkg::t_status  r_pend_status, n_pend_status;

    mts_pkg::t_mem_req mem_req;
    mts_pkg::t_word    mem_rdata;

    logic              accept;
    logic              out_free;
    logic              new_min;
    mts_pkg::t_count   room;
    mts_pkg::t_count   fill_dec;
    logic              res_fire;
    mts_pkg::t_word    res_value;
    mts_pkg::t_status  res_status;

    mts_store u_store (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rdata(mem_rdata)
    );

    // handshake
    assign i_in.ready         = (r_state == S_IDLE);
    assign accept             = i_in.valid && (r_state == S_IDLE);
    assign out_free           = !r_out_valid || o_out.ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.status       = r_out_status;

    // push room check and pop address
    assign new_min  = (i_in.push_value <= r_min);
    assign room     = mts_pkg::CNT_W'(mts_pkg::STORE_DEPTH) - r_fill;
    assign fill_dec = r_fill - mts_pkg::CNT_W'(1);

    // command sequencer
    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_min         = r_min;
        n_val         = r_val;
        res_fire      = 1'b0;
        res_value     = mts_pkg::ZERO_WORD;
        res_status    = mts_pkg::STAT_OK;
        mem_req.en    = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = r_fill[mts_pkg::ADDR_W-1:0];
        mem_req.wdata = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in.action)
                        mts_pkg::ACT_PUSH: begin
                            if ((new_min && room < mts_pkg::CNT_W'(2)) ||
                                (!new_min && room < mts_pkg::CNT_W'(1))) begin
                                res_fire   = 1'b1;
                                res_status = mts_pkg::STAT_FULL;
                            end else if (new_min) begin
                                // save old minimum first, value goes in next cycle
                                mem_req.en    = 1'b1;
                                mem_req.we    = 1'b1;
                                mem_req.wdata = r_min;
                                n_fill        = r_fill + mts_pkg::CNT_W'(1);
                                n_val         = i_in.push_value;
                                n_state       = S_PUSH2;
                            end else begin
                                mem_req.en    = 1'b1;
                                mem_req.we    = 1'b1;
                                mem_req.wdata = i_in.push_value;
                                n_fill        = r_fill + mts_pkg::CNT_W'(1);
                                res_fire      = 1'b1;
                            end
                        end
                        mts_pkg::ACT_POP: begin
                            if (r_fill == '0) begin
                                res_fire   = 1'b1;
                                res_value  = mts_pkg::EMPTY_WORD;
                                res_status = mts_pkg::STAT_EMPTY;
                            end else begin
                                mem_req.en   = 1'b1;
                                mem_req.addr = fill_dec[mts_pkg::ADDR_W-1:0];
                                n_fill       = fill_dec;
                                n_state      = S_POP1;
                            end
                        end
                        mts_pkg::ACT_QUERY: begin
                            res_fire = 1'b1;
                            if (r_fill == '0) begin
                                res_value  = mts_pkg::EMPTY_WORD;
                                res_status = mts_pkg::STAT_EMPTY;
                            end else begin
                                res_value = r_min;
                            end
                        end
                        default: begin
                            res_fire = 1'b1;
                        end
                    endcase
                end
            end
            S_PUSH2: begin
                // store the new minimum itself
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.wdata = r_val;
                n_fill        = r_fill + mts_pkg::CNT_W'(1);
                n_min         = r_val;
                res_fire      = 1'b1;
                n_state       = S_IDLE;
            end
            S_POP1: begin
                // top word is back from the store
                n_val = mem_rdata;
                if (mem_rdata == r_min && r_fill != '0) begin
                    mem_req.en   = 1'b1;
                    mem_req.addr = fill_dec[mts_pkg::ADDR_W-1:0];
                    n_fill       = fill_dec;
                    n_state      = S_POP2;
                end else begin
                    if (mem_rdata == r_min) begin
                        n_min = mts_pkg::MIN_RESET;
                    end
                    res_fire  = 1'b1;
                    res_value = mem_rdata;
                    n_state   = S_IDLE;
                end
            end
            S_POP2: begin
                // saved minimum comes back
                n_min     = mem_rdata;
                res_fire  = 1'b1;
                res_value = r_val;
                n_state   = S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a result that finds the output register busy waits in the holding register
        if (res_fire && !out_free) begin
            n_state = S_EMIT;
        end
    end

    // output register and holding register
    always_comb begin
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_value   = r_out_value;
        n_out_status  = r_out_status;
        n_pend_value  = r_pend_value;
        n_pend_status = r_pend_status;
        if (res_fire) begin
            n_pend_value  = res_value;
            n_pend_status = res_status;
        end
        if (res_fire && out_free) begin
            n_out_valid  = 1'b1;
            n_out_value  = res_value;
            n_out_status = res_status;
        end else if (r_state == S_EMIT && out_free) begin
            n_out_valid  = 1'b1;
            n_out_value  = r_pend_value;
            n_out_status = r_pend_status;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_min       <= mts_pkg::MIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_min       <= n_min;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_val         <= n_val;
        r_out_value   <= n_out_value;
        r_out_status  <= n_out_status;
        r_pend_value  <= n_pend_value;
        r_pend_status <= n_pend_status;
    end

    // fill count stays within the store
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= mts_pkg::CNT_W'(mts_pkg::STORE_DEPTH))
        else $error("fill count beyond store depth");

    // a held result only waits while the output register is occupied
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_out_valid)
        else $error("holding result with free output register");

    // an empty stack at rest always has the reset minimum
    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_fill == '0) |-> r_min == mts_pkg::MIN_RESET)
        else $error("empty stack with stale minimum");

    // a pop of a non-empty stack starts a store read
    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.action == mts_pkg::ACT_POP && r_fill != '0)
        |=> r_state == S_POP1)
        else $error("pop did not start a read");

endmodule

### src/mts_store.sv
// mts_store: single-port stack memory, one access per cycle, registered read
// depends on mts_pkg for depth, address and request types
module mts_store (
    input  logic              i_clk,
    input  mts_pkg::t_mem_req i_req,
    output mts_pkg::t_word    o_rdata
);

    mts_pkg::t_word r_mem [mts_pkg::STORE_DEPTH];
    mts_pkg::t_word r_rdata;

    // write or read the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[i_req.addr] <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
